/* hdl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and block set-up function for the stream cipher unit.
// ----------------------------------------------------------------------------
package cc20_pkg;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

   localparam logic [31:0] INIT_CTR_RESET = 32'd1;

   typedef enum logic [2:0] {
      REG_KEY_01   = 3'd0,
      REG_KEY_23   = 3'd1,
      REG_KEY_45   = 3'd2,
      REG_KEY_67   = 3'd3,
      REG_NONCE_01 = 3'd4,
      REG_NONCE_2  = 3'd5,
      REG_INIT_CTR = 3'd6
   } cc20_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_EMIT
   } cc20_state_type;

   typedef logic [15:0][31:0] cc20_block_type;

   typedef struct packed {
      logic [7:0][31:0] key;
      logic [2:0][31:0] nonce;
      logic [31:0]      init_ctr;
   } cc20_cfg_type;

   typedef struct packed {
      logic       take_in;
      logic       load_init;
      logic       run_step;
      logic [1:0] step;
      logic       diag;
      logic       finish;
      logic       emit;
   } cc20_cmd_type;

   typedef struct packed {
      logic need_block;
      logic out_free;
   } cc20_status_type;

   function automatic cc20_block_type cc20_init_words(input cc20_cfg_type cfg,
                                                      input logic [31:0] counter);
      cc20_block_type w;
      w[0] = SIGMA0;
      w[1] = SIGMA1;
      w[2] = SIGMA2;
      w[3] = SIGMA3;
      for (int i = 0; i < 8; i++) begin
         w[4 + i] = cfg.key[i];
      end
      w[12] = counter;
      w[13] = cfg.nonce[0];
      w[14] = cfg.nonce[1];
      w[15] = cfg.nonce[2];
      return w;
   endfunction

endpackage

/* hdl/cc20_if.sv */
// ----------------------------------------------------------------------------
// cc20_req_if / cc20_rsp_if
// Valid/ready channels carrying message bytes in and cipher bytes out.
// ----------------------------------------------------------------------------
interface cc20_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cc20_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink (input valid, input out_byte, output ready);
endinterface

/* hdl/chacha20_stream_cipher_unit.sv */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit
// Byte-wide ChaCha20 (IETF, 96-bit nonce, 32-bit wrapping block counter)
// encrypt/decrypt. One transaction in gives one byte out: the input byte XOR
// the next keystream byte. A byte whose keystream block is already buffered
// is accepted, then loaded into the output register. The first byte of a
// message and every 64th byte after it also wait for a new block: set-up,
// the rounds, which the four shared quarter-round lanes run at one
// add/xor/rotate step per cycle, and the final add. One byte is in flight
// at a time; the output register holds a finished byte while the next one
// is accepted. A byte with last_byte set ends the message and the next
// starts from initial_counter. Registers sit at byte address 8 * index on
// the 64-bit APB port; key, nonce and counter writes act from the next
// block or message.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit
   import cc20_pkg::*;
#(
   parameter int ROUNDS = 20
)
(
   input  logic                  clock,
   input  logic                  reset,
   cc20_req_if.sink              req_ch,
   cc20_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cc20_cfg_type    cfg;
   cc20_cmd_type    cmd;
   cc20_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic [7:0]      rsp_out_byte;

   cc20_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cc20_ctrl #(
      .ROUNDS (ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cc20_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg),
      .req_data_byte (req_ch.data_byte),
      .req_last_byte (req_ch.last_byte),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte)
   );

   assign req_ch.ready    = req_ready;
   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.out_byte = rsp_out_byte;

endmodule

/* hdl/cc20_csr.sv */
// ----------------------------------------------------------------------------
// cc20_csr
// APB-style register file for key, nonce and initial block counter.
// ----------------------------------------------------------------------------
module cc20_csr
   import cc20_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cc20_cfg_type          cfg
);

   cc20_cfg_type cfg_ff;
   cc20_cfg_type cfg_in;
   cc20_reg_type reg_sel;
   logic         wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = cc20_reg_type'(paddr[5:3]);
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_KEY_01: begin
               cfg_in.key[0] = pwdata[31:0];
               cfg_in.key[1] = pwdata[63:32];
            end
            REG_KEY_23: begin
               cfg_in.key[2] = pwdata[31:0];
               cfg_in.key[3] = pwdata[63:32];
            end
            REG_KEY_45: begin
               cfg_in.key[4] = pwdata[31:0];
               cfg_in.key[5] = pwdata[63:32];
            end
            REG_KEY_67: begin
               cfg_in.key[6] = pwdata[31:0];
               cfg_in.key[7] = pwdata[63:32];
            end
            REG_NONCE_01: begin
               cfg_in.nonce[0] = pwdata[31:0];
               cfg_in.nonce[1] = pwdata[63:32];
            end
            REG_NONCE_2: begin
               cfg_in.nonce[2] = pwdata[31:0];
            end
            REG_INIT_CTR: begin
               cfg_in.init_ctr = pwdata[31:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_KEY_01:   prdata = {cfg_ff.key[1], cfg_ff.key[0]};
         REG_KEY_23:   prdata = {cfg_ff.key[3], cfg_ff.key[2]};
         REG_KEY_45:   prdata = {cfg_ff.key[5], cfg_ff.key[4]};
         REG_KEY_67:   prdata = {cfg_ff.key[7], cfg_ff.key[6]};
         REG_NONCE_01: prdata = {cfg_ff.nonce[1], cfg_ff.nonce[0]};
         REG_NONCE_2:  prdata = {32'd0, cfg_ff.nonce[2]};
         REG_INIT_CTR: prdata = {32'd0, cfg_ff.init_ctr};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{key: '0, nonce: '0, init_ctr: INIT_CTR_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/cc20_ctrl.sv */
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: accepts a byte, runs block generation when needed, issues result.
// ----------------------------------------------------------------------------
module cc20_ctrl
   import cc20_pkg::*;
#(
   parameter int ROUNDS = 20
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  cc20_status_type status,
   output cc20_cmd_type    cmd
);

   localparam int STEP_COUNT = 8 * (ROUNDS / 2);
   localparam int STEP_W     = $clog2(STEP_COUNT);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEP_COUNT - 1);

   cc20_state_type    state_ff;
   cc20_state_type    state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.step  = step_ff[1:0];
      cmd.diag  = step_ff[2];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_in = 1'b1;
               state_in    = status.need_block ? ST_LOAD : ST_EMIT;
            end
         end
         ST_LOAD: begin
            cmd.load_init = 1'b1;
            step_in       = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.run_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/cc20_datapath.sv */
// ----------------------------------------------------------------------------
// cc20_datapath
// Round words with four quarter-round lanes, keystream buffer, byte output.
// ----------------------------------------------------------------------------
module cc20_datapath
   import cc20_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cc20_cmd_type    cmd,
   output cc20_status_type status,
   input  cc20_cfg_type    cfg,
   input  logic [7:0]      req_data_byte,
   input  logic            req_last_byte,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_byte
);

   cc20_block_type round_words_ff;
   cc20_block_type round_words_in;
   cc20_block_type keystream_words_ff;
   cc20_block_type keystream_words_in;
   cc20_block_type init_words;
   cc20_block_type step_words;
   cc20_block_type final_words;

   logic [31:0] block_count_ff;
   logic [31:0] block_count_in;
   logic [5:0]  byte_offset_ff;
   logic [5:0]  byte_offset_in;
   logic        block_ready_ff;
   logic        block_ready_in;
   logic        msg_started_ff;
   logic        msg_started_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  in_data_ff;
   logic [7:0]  in_data_in;
   logic        in_last_ff;
   logic        in_last_in;
   logic [7:0]  out_byte_ff;
   logic [7:0]  out_byte_in;

   logic [3:0][3:0]  lane_x_idx;
   logic [3:0][3:0]  lane_z_idx;
   logic [3:0][31:0] lane_x_val;
   logic [3:0][31:0] lane_z_val;

   logic [31:0] ks_word;
   logic [7:0]  ks_byte;

   assign init_words = cc20_init_words(cfg, block_count_ff);

   // quarter-round lanes, one add/xor/rotate step per cycle
   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [1:0]  lb;
      logic [1:0]  lc;
      logic [1:0]  ld;
      logic [3:0]  ix;
      logic [3:0]  iy;
      logic [3:0]  iz;
      logic [31:0] sum;
      logic [31:0] mixed;
      logic [31:0] rot;

      assign lb    = 2'(l) + {1'b0, cmd.diag};
      assign lc    = 2'(l) + {cmd.diag, 1'b0};
      assign ld    = 2'(l) + {cmd.diag, cmd.diag};
      assign ix    = cmd.step[0] ? {2'b10, lc} : {2'b00, 2'(l)};
      assign iy    = cmd.step[0] ? {2'b11, ld} : {2'b01, lb};
      assign iz    = cmd.step[0] ? {2'b01, lb} : {2'b11, ld};
      assign sum   = round_words_ff[ix] + round_words_ff[iy];
      assign mixed = sum ^ round_words_ff[iz];

      always_comb begin
         unique case (cmd.step)
            2'd0:    rot = {mixed[15:0], mixed[31:16]};
            2'd1:    rot = {mixed[19:0], mixed[31:20]};
            2'd2:    rot = {mixed[23:0], mixed[31:24]};
            default: rot = {mixed[24:0], mixed[31:25]};
         endcase
      end

      assign lane_x_idx[l] = ix;
      assign lane_z_idx[l] = iz;
      assign lane_x_val[l] = sum;
      assign lane_z_val[l] = rot;
   end

   always_comb begin
      step_words = round_words_ff;
      for (int l = 0; l < 4; l++) begin
         step_words[lane_x_idx[l]] = lane_x_val[l];
         step_words[lane_z_idx[l]] = lane_z_val[l];
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         final_words[i] = round_words_ff[i] + init_words[i];
      end
   end

   assign ks_word = keystream_words_ff[byte_offset_ff[5:2]];
   assign ks_byte = ks_word[{byte_offset_ff[1:0], 3'b000} +: 8];

   // payload
   always_comb begin
      in_data_in         = cmd.take_in ? req_data_byte : in_data_ff;
      in_last_in         = cmd.take_in ? req_last_byte : in_last_ff;
      keystream_words_in = cmd.finish ? final_words : keystream_words_ff;
      out_byte_in        = cmd.emit ? (in_data_ff ^ ks_byte) : out_byte_ff;
      round_words_in     = round_words_ff;
      if (cmd.load_init) begin
         round_words_in = init_words;
      end else if (cmd.run_step) begin
         round_words_in = step_words;
      end
   end

   // stream position and block bookkeeping
   always_comb begin
      block_count_in = block_count_ff;
      byte_offset_in = byte_offset_ff;
      block_ready_in = block_ready_ff;
      msg_started_in = msg_started_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      if (cmd.take_in && !msg_started_ff) begin
         block_count_in = cfg.init_ctr;
         byte_offset_in = '0;
         block_ready_in = 1'b0;
         msg_started_in = 1'b1;
      end
      if (cmd.finish) begin
         block_count_in = block_count_ff + 32'd1;
         block_ready_in = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         byte_offset_in = byte_offset_ff + 6'd1;
         if (byte_offset_ff == 6'h3f) begin
            block_ready_in = 1'b0;
         end
         if (in_last_ff) begin
            byte_offset_in = '0;
            block_ready_in = 1'b0;
            msg_started_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= INIT_CTR_RESET;
         byte_offset_ff <= '0;
         block_ready_ff <= 1'b0;
         msg_started_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         block_count_ff <= block_count_in;
         byte_offset_ff <= byte_offset_in;
         block_ready_ff <= block_ready_in;
         msg_started_ff <= msg_started_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff         <= in_data_in;
      in_last_ff         <= in_last_in;
      round_words_ff     <= round_words_in;
      keystream_words_ff <= keystream_words_in;
      out_byte_ff        <= out_byte_in;
   end

   assign status.need_block = ~(block_ready_ff & msg_started_ff);
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;

endmodule

/* hdl/cc20_checker.sv */
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks on the stream cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
module cc20_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte))
      else $error("result byte changed while stalled");

   // one byte in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted before result was issued");

   // a new result only comes from a byte already taken in
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result issued while input side was idle");

endmodule

bind chacha20_stream_cipher_unit cc20_checker u_cc20_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_byte (rsp_ch.out_byte)
);
